// File: rtl/core/key_value_rule_table_core_assert.svh
// Assertion macros shared by the key/value rule table RTL.
`ifndef KEY_VALUE_RULE_TABLE_CORE_ASSERT_SVH
`define KEY_VALUE_RULE_TABLE_CORE_ASSERT_SVH

// Property checked on every rising edge of clk_i outside reset.
`define KVRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define KVRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/kvrt_pkg.sv
// Package with constants, codes and payload types of the key/value rule table.
`default_nettype none

package kvrt_pkg;

  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned COUNT_OUT_W = 9;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [VAL_W-1:0]       found_value;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [VAL_W-1:0] hit_value;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } scan_res_t;

endpackage

`default_nettype wire

// File: rtl/core/kvrt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module kvrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/kvrt_scan.sv
// Sweep engine that reads every entry once and finds the first key match and first free slot.
`default_nettype none

module kvrt_scan (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [kvrt_pkg::KEY_W-1:0]     key_i,
  input  wire logic                           vld_bit_i,
  output logic      [kvrt_pkg::IDX_W-1:0]     rd_addr_o,
  input  wire kvrt_pkg::entry_t               rd_data_i,
  output kvrt_pkg::scan_res_t                 res_o
);

  localparam logic [kvrt_pkg::IDX_W-1:0] LastIdx = kvrt_pkg::IDX_W'(kvrt_pkg::ENTRIES - 1);

  logic                          busy_q, busy_d;
  logic [kvrt_pkg::IDX_W-1:0]    cnt_q, cnt_d;
  logic                          live_q, last_q, pvld_q;
  logic [kvrt_pkg::IDX_W-1:0]    pidx_q;
  logic                          done_q;
  logic                          hit_q, hit_d, free_q, free_d;
  logic [kvrt_pkg::IDX_W-1:0]    hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [kvrt_pkg::VAL_W-1:0]    hit_val_q, hit_val_d;

  assign rd_addr_o = cnt_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == LastIdx) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_val_d  = hit_val_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (start_i) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (live_q) begin
      if (pvld_q && !hit_q && (rd_data_i.key == key_i)) begin
        hit_d     = 1'b1;
        hit_idx_d = pidx_q;
        hit_val_d = rd_data_i.value;
      end
      if (!pvld_q && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = pidx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      live_q <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      live_q <= busy_q && !start_i;
      last_q <= busy_q && (cnt_q == LastIdx);
      done_q <= live_q && last_q;
      hit_q  <= hit_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pvld_q     <= vld_bit_i;
    pidx_q     <= cnt_q;
    hit_idx_q  <= hit_idx_d;
    hit_val_q  <= hit_val_d;
    free_idx_q <= free_idx_d;
  end

  always_comb begin
    res_o.done      = done_q;
    res_o.hit       = hit_q;
    res_o.hit_idx   = hit_idx_q;
    res_o.hit_value = hit_val_q;
    res_o.free      = free_q;
    res_o.free_idx  = free_idx_q;
  end

endmodule

`default_nettype wire

// File: rtl/core/key_value_rule_table_core.sv
// One request is processed at a time: a new request is accepted only once the previous
// response has been loaded into the output register, after the sweep that reads one
// entry per cycle through the single read port of the key/value memory.
// Reset clears all valid bits, the entry count and the control state at once;
// the key/value memory needs no clearing and the table takes requests right after reset.
`default_nettype none
`include "key_value_rule_table_core_assert.svh"

module key_value_rule_table_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire kvrt_pkg::req_t req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_ready_i,
  output kvrt_pkg::rsp_t      rsp_o
);

  localparam logic [1:0] STATE_IDLE = 2'd0;
  localparam logic [1:0] STATE_SCAN = 2'd1;
  localparam logic [1:0] STATE_DONE = 2'd2;

  logic [1:0]                      state_q, state_d;
  kvrt_pkg::req_t                  req_q;
  logic [kvrt_pkg::ENTRIES-1:0]    valid_q, valid_d;
  logic [kvrt_pkg::CNT_W-1:0]      count_q, count_d;
  kvrt_pkg::rsp_t                  pend_q, pend_d;
  kvrt_pkg::rsp_t                  out_q;
  logic                            out_valid_q, out_valid_d;
  logic                            out_load;
  logic                            accept;
  logic                            we;
  logic [kvrt_pkg::IDX_W-1:0]      waddr;
  logic [kvrt_pkg::IDX_W-1:0]      raddr;
  kvrt_pkg::entry_t                wdata;
  kvrt_pkg::entry_t                rdata;
  kvrt_pkg::scan_res_t             res;
  logic [kvrt_pkg::CNT_W+kvrt_pkg::COUNT_OUT_W-1:0] cnt_ext;

  assign req_ready_o = (state_q == STATE_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  kvrt_ram #(
    .WIDTH($bits(kvrt_pkg::entry_t)),
    .DEPTH(kvrt_pkg::ENTRIES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  kvrt_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .key_i    (req_q.key),
    .vld_bit_i(valid_q[raddr]),
    .rd_addr_o(raddr),
    .rd_data_i(rdata),
    .res_o    (res)
  );

  assign wdata.key   = req_q.key;
  assign wdata.value = req_q.value;

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    count_d = count_q;
    pend_d  = pend_q;
    we      = 1'b0;
    waddr   = res.hit ? res.hit_idx : res.free_idx;
    cnt_ext = '0;
    case (state_q)
      STATE_IDLE: begin
        if (accept) begin
          state_d = STATE_SCAN;
        end
      end
      STATE_SCAN: begin
        if (res.done) begin
          state_d            = STATE_DONE;
          pend_d.status      = kvrt_pkg::ST_OK;
          pend_d.found_value = '0;
          case (req_q.operation)
            kvrt_pkg::OP_LOOKUP: begin
              if (res.hit) begin
                pend_d.found_value = res.hit_value;
              end else begin
                pend_d.status = kvrt_pkg::ST_NOT_FOUND;
              end
            end
            kvrt_pkg::OP_INSERT: begin
              if (res.hit) begin
                we = 1'b1;
              end else if (res.free) begin
                we             = 1'b1;
                valid_d[waddr] = 1'b1;
                count_d        = count_q + 1'b1;
              end else begin
                pend_d.status = kvrt_pkg::ST_FULL;
              end
            end
            kvrt_pkg::OP_DELETE: begin
              if (res.hit) begin
                valid_d[res.hit_idx] = 1'b0;
                if (count_q != '0) begin
                  count_d = count_q - 1'b1;
                end
              end else begin
                pend_d.status = kvrt_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
          cnt_ext            = (kvrt_pkg::CNT_W + kvrt_pkg::COUNT_OUT_W)'(count_d);
          pend_d.entry_count = cnt_ext[kvrt_pkg::COUNT_OUT_W-1:0];
        end
      end
      STATE_DONE: begin
        if (out_load) begin
          state_d = STATE_IDLE;
        end
      end
      default: begin
        state_d = STATE_IDLE;
      end
    endcase
  end

  assign out_load = (state_q == STATE_DONE) && (!out_valid_q || rsp_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  `KVRT_ASSERT(a_count_bound, count_q <= kvrt_pkg::CNT_W'(kvrt_pkg::ENTRIES), "count above size")
  `KVRT_ASSERT_NEXT(a_accept_scan, accept, state_q == STATE_SCAN, "no scan after accept")
  `KVRT_ASSERT_NEXT(a_count_only_done, !res.done, $stable(count_q), "count moved off done")
  `KVRT_ASSERT(a_done_in_scan, !res.done || (state_q == STATE_SCAN), "scan done outside scan")

endmodule

`default_nettype wire
